// File: sv/scp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types, constants and command text tables of the sensor command parser.
// ----------------------------------------------------------------------------
package scp_pkg;

  // Command kinds as reported on the result side
  typedef enum logic [2:0] {
    KIND_OFF    = 3'd0,
    KIND_START  = 3'd1,
    KIND_STOP   = 3'd2,
    KIND_PERIOD = 3'd3,
    KIND_SCALE  = 3'd4,
    KIND_DISP   = 3'd5,
    KIND_NONE   = 3'd6
  } kind_e;

  localparam int unsigned NumCmds    = 6;
  localparam int unsigned NumExact   = 3;
  localparam logic [3:0]  PosMax     = 4'd15;
  localparam logic [3:0]  PosArgLo   = 4'd5;
  localparam logic [3:0]  PosArgHi   = 4'd6;
  localparam logic [3:0]  PosDigits  = 4'd7;
  localparam logic [11:0] AccumMax   = 12'd4095;
  localparam logic [11:0] PeriodMax  = 12'd3600;
  localparam logic [11:0] PeriodInit = 12'd3;
  localparam int unsigned ScaleBit   = 4;

  // Classified message handed from front to back
  typedef struct packed {
    kind_e       kind;
    logic        arg_ok;
    logic        arg_bit;
    logic [11:0] period;
  } msg_t;

  // Queue status seen by its producer and consumer
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  // Length of each command text (prefix length for argument commands)
  function automatic logic [3:0] cmd_len(input logic [2:0] k);
    logic [3:0] len;
    case (k)
      3'd0:    len = 4'd3;
      3'd1:    len = 4'd5;
      3'd2:    len = 4'd4;
      3'd3:    len = 4'd7;
      3'd4:    len = 4'd6;
      3'd5:    len = 4'd5;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  // Character of command k at position p
  function automatic logic [7:0] cmd_char(input logic [2:0] k, input logic [3:0] p);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      3'd0: begin
        case (p)
          4'd0:    ch = "O";
          4'd1:    ch = "F";
          4'd2:    ch = "F";
          default: ch = 8'h00;
        endcase
      end
      3'd1: begin
        case (p)
          4'd0:    ch = "S";
          4'd1:    ch = "T";
          4'd2:    ch = "A";
          4'd3:    ch = "R";
          4'd4:    ch = "T";
          default: ch = 8'h00;
        endcase
      end
      3'd2: begin
        case (p)
          4'd0:    ch = "S";
          4'd1:    ch = "T";
          4'd2:    ch = "O";
          4'd3:    ch = "P";
          default: ch = 8'h00;
        endcase
      end
      3'd3: begin
        case (p)
          4'd0:    ch = "P";
          4'd1:    ch = "E";
          4'd2:    ch = "R";
          4'd3:    ch = "I";
          4'd4:    ch = "O";
          4'd5:    ch = "D";
          4'd6:    ch = "=";
          default: ch = 8'h00;
        endcase
      end
      3'd4: begin
        case (p)
          4'd0:    ch = "S";
          4'd1:    ch = "C";
          4'd2:    ch = "A";
          4'd3:    ch = "L";
          4'd4:    ch = "E";
          4'd5:    ch = "=";
          default: ch = 8'h00;
        endcase
      end
      3'd5: begin
        case (p)
          4'd0:    ch = "D";
          4'd1:    ch = "I";
          4'd2:    ch = "S";
          4'd3:    ch = "P";
          4'd4:    ch = " ";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: sv/scp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_front
// Byte matcher: tracks per-message parse state and classifies each message
// on its last byte into a record for the back end.
// ----------------------------------------------------------------------------
module scp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic [7:0]    message_byte_i,
  input  logic          last_byte_i,
  output logic          msg_push_o,
  output scp_pkg::msg_t msg_o
);

  logic [3:0]  pos_q, pos_d;
  logic [5:0]  mask_q, mask_d;
  logic [11:0] acc_q, acc_d;
  logic        dok_q, dok_d;
  logic [7:0]  arg_q, arg_d;
  logic        end_q, end_d;

  logic [5:0]  mask_n;
  logic [3:0]  pos_n;
  logic [11:0] acc_n;
  logic        dok_n;
  logic [7:0]  arg_n;
  logic        end_n;
  logic [15:0] prod;
  logic        is_digit;

  // Advance the parse state by one byte
  always_comb begin
    mask_n   = mask_q;
    pos_n    = pos_q;
    acc_n    = acc_q;
    dok_n    = dok_q;
    arg_n    = arg_q;
    end_n    = end_q;
    is_digit = (message_byte_i >= "0") && (message_byte_i <= "9");
    prod     = ({4'd0, acc_q} * 16'd10) + {12'd0, message_byte_i[3:0]};
    if (!end_q) begin
      if (message_byte_i == 8'h00) begin
        end_n = 1'b1;
      end else begin
        for (int k = 0; k < scp_pkg::NumCmds; k++) begin
          if (pos_q < scp_pkg::cmd_len(3'(k))) begin
            if (scp_pkg::cmd_char(3'(k), pos_q) != message_byte_i) mask_n[k] = 1'b0;
          end else if (k < scp_pkg::NumExact) begin
            mask_n[k] = 1'b0;
          end
        end
        if (pos_q >= scp_pkg::PosDigits) begin
          if (is_digit) begin
            acc_n = (prod > {4'd0, scp_pkg::AccumMax}) ? scp_pkg::AccumMax : prod[11:0];
          end else begin
            dok_n = 1'b0;
          end
        end
        if (pos_q == scp_pkg::PosArgLo) begin
          arg_n = message_byte_i;
        end else if (pos_q == scp_pkg::PosArgHi && mask_n[scp_pkg::ScaleBit]) begin
          arg_n = message_byte_i;
        end
        if (pos_q != scp_pkg::PosMax) pos_n = pos_q + 4'd1;
      end
    end
  end

  // Classify the finished message
  always_comb begin
    msg_o.kind    = scp_pkg::KIND_NONE;
    msg_o.arg_ok  = 1'b0;
    msg_o.arg_bit = 1'b0;
    msg_o.period  = acc_n;
    if (mask_n[0] && pos_n == 4'd3) begin
      msg_o.kind   = scp_pkg::KIND_OFF;
      msg_o.arg_ok = 1'b1;
    end else if (mask_n[1] && pos_n == 4'd5) begin
      msg_o.kind   = scp_pkg::KIND_START;
      msg_o.arg_ok = 1'b1;
    end else if (mask_n[2] && pos_n == 4'd4) begin
      msg_o.kind   = scp_pkg::KIND_STOP;
      msg_o.arg_ok = 1'b1;
    end else if (mask_n[3] && pos_n >= 4'd7) begin
      msg_o.kind   = scp_pkg::KIND_PERIOD;
      msg_o.arg_ok = dok_n && (acc_n >= 12'd1) && (acc_n <= scp_pkg::PeriodMax);
    end else if (mask_n[4] && pos_n >= 4'd6) begin
      msg_o.kind    = scp_pkg::KIND_SCALE;
      msg_o.arg_ok  = (pos_n == 4'd7) && (arg_n == "F" || arg_n == "C");
      msg_o.arg_bit = (arg_n == "C");
    end else if (mask_n[5] && pos_n >= 4'd5) begin
      msg_o.kind    = scp_pkg::KIND_DISP;
      msg_o.arg_ok  = (pos_n == 4'd6) && (arg_n == "Y" || arg_n == "N");
      msg_o.arg_bit = (arg_n == "Y");
    end
  end

  assign msg_push_o = take_i && last_byte_i;

  // Load the next parse state; clear it after the last byte
  always_comb begin
    pos_d  = pos_q;
    mask_d = mask_q;
    acc_d  = acc_q;
    dok_d  = dok_q;
    arg_d  = arg_q;
    end_d  = end_q;
    if (take_i) begin
      if (last_byte_i) begin
        pos_d  = 4'd0;
        mask_d = '1;
        acc_d  = 12'd0;
        dok_d  = 1'b1;
        arg_d  = 8'h00;
        end_d  = 1'b0;
      end else begin
        pos_d  = pos_n;
        mask_d = mask_n;
        acc_d  = acc_n;
        dok_d  = dok_n;
        arg_d  = arg_n;
        end_d  = end_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 4'd0;
      mask_q <= '1;
      acc_q  <= 12'd0;
      dok_q  <= 1'b1;
      arg_q  <= 8'h00;
      end_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      mask_q <= mask_d;
      acc_q  <= acc_d;
      dok_q  <= dok_d;
      arg_q  <= arg_d;
      end_q  <= end_d;
    end
  end

endmodule

// File: sv/scp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_queue
// Two-entry queue of classified messages between front and back end.
// ----------------------------------------------------------------------------
module scp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  scp_pkg::msg_t  data_i,
  input  logic           pop_i,
  output scp_pkg::msg_t  data_o,
  output scp_pkg::qstat_t stat_o
);

  scp_pkg::msg_t slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign stat_o.empty = (cnt_q == 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = slot_q[rd_q];

  // Advance pointers and fill count
  always_comb begin
    wr_d  = do_push ? !wr_q : wr_q;
    rd_d  = do_pop ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the pushed record
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= data_i;
  end

endmodule

// File: sv/scp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_back
// Executes classified commands on the kept settings and holds the result
// in an output register until it is taken.
// ----------------------------------------------------------------------------
module scp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scp_pkg::msg_t   msg_i,
  input  scp_pkg::qstat_t qstat_i,
  output logic            msg_pop_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [2:0]      command_kind_o,
  output logic            invalid_o,
  output logic            power_off_o,
  output logic            sending_o,
  output logic            celsius_o,
  output logic            display_on_o,
  output logic [11:0]     period_seconds_o
);

  logic        off_q, off_d;
  logic        send_q, send_d;
  logic        cel_q, cel_d;
  logic        disp_q, disp_d;
  logic [11:0] per_q, per_d;
  logic        ovld_q, ovld_d;
  logic [2:0]  okind_q;
  logic        oinv_q;
  logic        ooff_q, osend_q, ocel_q, odisp_q;
  logic [11:0] oper_q;
  logic        load;

  // Take a record when the output slot is free or being emptied
  assign load      = !qstat_i.empty && (!ovld_q || pop_i);
  assign msg_pop_o = load;

  // Apply the command to the settings
  always_comb begin
    off_d  = off_q;
    send_d = send_q;
    cel_d  = cel_q;
    disp_d = disp_q;
    per_d  = per_q;
    if (load && msg_i.arg_ok) begin
      case (msg_i.kind)
        scp_pkg::KIND_OFF:    off_d  = 1'b1;
        scp_pkg::KIND_START:  send_d = 1'b1;
        scp_pkg::KIND_STOP:   send_d = 1'b0;
        scp_pkg::KIND_PERIOD: per_d  = msg_i.period;
        scp_pkg::KIND_SCALE:  cel_d  = msg_i.arg_bit;
        scp_pkg::KIND_DISP:   disp_d = msg_i.arg_bit;
        default:              off_d  = off_q;
      endcase
    end
  end

  // Track output slot occupancy
  always_comb begin
    ovld_d = ovld_q;
    if (load) begin
      ovld_d = 1'b1;
    end else if (pop_i) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q  <= 1'b0;
      send_q <= 1'b1;
      cel_q  <= 1'b0;
      disp_q <= 1'b1;
      per_q  <= scp_pkg::PeriodInit;
      ovld_q <= 1'b0;
    end else begin
      off_q  <= off_d;
      send_q <= send_d;
      cel_q  <= cel_d;
      disp_q <= disp_d;
      per_q  <= per_d;
      ovld_q <= ovld_d;
    end
  end

  // Capture the result with the updated settings
  always_ff @(posedge clk_i) begin
    if (load) begin
      okind_q <= msg_i.kind;
      oinv_q  <= !msg_i.arg_ok;
      ooff_q  <= off_d;
      osend_q <= send_d;
      ocel_q  <= cel_d;
      odisp_q <= disp_d;
      oper_q  <= per_d;
    end
  end

  assign empty_o          = !ovld_q;
  assign command_kind_o   = okind_q;
  assign invalid_o        = oinv_q;
  assign power_off_o      = ooff_q;
  assign sending_o        = osend_q;
  assign celsius_o        = ocel_q;
  assign display_on_o     = odisp_q;
  assign period_seconds_o = oper_q;

endmodule

// File: sv/sensor_command_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_command_parser_top
// Parses framed text commands one byte per cycle and reports the command
// kind, a reject flag and the kept sensor settings once per message.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  input    | push / full        | message_byte_i, last_byte_i
//  result   | pop / empty        | command_kind_o, invalid_o, power_off_o,
//           |                    | sending_o, celsius_o, display_on_o,
//           |                    | period_seconds_o
//
// One byte is taken per cycle while full is low; the byte matcher updates
// its state in the cycle of the transfer. A message's result reaches the
// result ports through the message queue, then the output register, with
// one result per cycle sustained while pop is held.
// After reset the settings are off 0, sending 1, Celsius 0, display 1,
// period 3. full rises while the two-entry message queue is full, which
// happens only when results are not popped.
// ----------------------------------------------------------------------------
module sensor_command_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  message_byte_i,
  input  logic        last_byte_i,
  input  logic        pop,
  output logic        empty,
  output logic [2:0]  command_kind_o,
  output logic        invalid_o,
  output logic        power_off_o,
  output logic        sending_o,
  output logic        celsius_o,
  output logic        display_on_o,
  output logic [11:0] period_seconds_o
);

  scp_pkg::msg_t   front_msg;
  scp_pkg::msg_t   back_msg;
  scp_pkg::qstat_t qstat;
  logic            take;
  logic            msg_push;
  logic            msg_pop;

  // Accept a byte on each transfer
  assign full = qstat.full;
  assign take = push && !qstat.full;

  scp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .message_byte_i (message_byte_i),
    .last_byte_i    (last_byte_i),
    .msg_push_o     (msg_push),
    .msg_o          (front_msg)
  );

  scp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (msg_push),
    .data_i (front_msg),
    .pop_i  (msg_pop),
    .data_o (back_msg),
    .stat_o (qstat)
  );

  scp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .msg_i            (back_msg),
    .qstat_i          (qstat),
    .msg_pop_o        (msg_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .command_kind_o   (command_kind_o),
    .invalid_o        (invalid_o),
    .power_off_o      (power_off_o),
    .sending_o        (sending_o),
    .celsius_o        (celsius_o),
    .display_on_o     (display_on_o),
    .period_seconds_o (period_seconds_o)
  );

endmodule

// File: bench/tb_sensor_command_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_command_parser_top
// Feeds framed command texts byte by byte into the parser. A directed set of
// commands comes first, then about two thousand random bytes, most of them
// well-formed commands with random arguments and the rest corrupted texts and
// noise. A predictor tracks the kept settings and the per-message matcher and
// queues one expected report per last byte. The monitor checks each popped
// report field by field. Both sides idle in random bursts. The receiver holds
// off once so that the input stalls, and the sender once waits for all
// reports to come back.
// ----------------------------------------------------------------------------
module tb_sensor_command_parser_top;
  import scp_pkg::*;

  localparam int ClkPeriod     = 10;
  localparam int ResetCycles   = 12;
  localparam int RandomItems   = 2000;
  localparam int CalmItems     = 200;
  localparam int HoldOffAfter  = 40;
  localparam int HoldOffCycles = 80;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  typedef struct packed {
    kind_e       kind;
    logic        invalid;
    logic        power_off;
    logic        sending;
    logic        celsius;
    logic        display_on;
    logic [11:0] period;
  } report_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        push           = 1'b0;
  logic        full;
  logic [7:0]  message_byte_i = 8'h00;
  logic        last_byte_i    = 1'b0;
  logic        pop            = 1'b0;
  logic        empty;
  logic [2:0]  command_kind_o;
  logic        invalid_o;
  logic        power_off_o;
  logic        sending_o;
  logic        celsius_o;
  logic        display_on_o;
  logic [11:0] period_seconds_o;

  sensor_command_parser_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .message_byte_i   (message_byte_i),
    .last_byte_i      (last_byte_i),
    .pop              (pop),
    .empty            (empty),
    .command_kind_o   (command_kind_o),
    .invalid_o        (invalid_o),
    .power_off_o      (power_off_o),
    .sending_o        (sending_o),
    .celsius_o        (celsius_o),
    .display_on_o     (display_on_o),
    .period_seconds_o (period_seconds_o)
  );

  // Command words, indexed by command kind
  string cmd_word [NumCmds] = '{"OFF", "START", "STOP", "PERIOD=", "SCALE=", "DISP "};

  msg_byte_t   pending_q [$];
  report_t     expected_q [$];
  logic [7:0]  msg_buf [$];
  int unsigned sent_cnt     = 0;
  int unsigned total_items  = 0;
  int unsigned pause_at     = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles  = 0;
  bit          calm         = 1'b0;

  // Kept settings and per-message matcher state of the predictor
  logic        off_s, send_s, cels_s, disp_s;
  logic [11:0] period_s;
  logic [3:0]  pos_s;
  logic [5:0]  cand_s;
  logic [11:0] accum_s;
  logic        digits_ok_s;
  logic        ended_s;
  logic [7:0]  arg_s;

  // Clear the matcher for the next message
  function automatic void restart_message();
    pos_s       = '0;
    cand_s      = '1;
    accum_s     = '0;
    digits_ok_s = 1'b1;
    arg_s       = '0;
    ended_s     = 1'b0;
  endfunction

  // Advance the matcher by one text character
  function automatic void match_char(input logic [7:0] c);
    int unsigned p;
    int unsigned v;
    p = pos_s;
    // drop every command whose text disagrees at this position
    for (int k = 0; k < NumCmds; k++) begin
      if (p < cmd_word[k].len()) begin
        if (cmd_word[k][p] != c) cand_s[k] = 1'b0;
      end else if (k < NumExact) begin
        cand_s[k] = 1'b0;
      end
    end
    // accumulate the decimal argument, saturating
    if (p >= PosDigits) begin
      if (c >= "0" && c <= "9") begin
        v = accum_s * 10 + (c - "0");
        accum_s = (v > AccumMax) ? AccumMax : v[11:0];
      end else begin
        digits_ok_s = 1'b0;
      end
    end
    // capture the argument letter of SCALE or DISP
    if (p == PosArgLo) begin
      arg_s = c;
    end else if (p == PosArgHi && cand_s[ScaleBit]) begin
      arg_s = c;
    end
    if (pos_s < PosMax) pos_s++;
  endfunction

  // Take one accepted byte; return 1 with the expected report on a last byte
  function automatic bit predict_byte(input msg_byte_t b, output report_t r);
    r = '0;
    if (!ended_s) begin
      if (b.data == 8'h00) begin
        ended_s = 1'b1;
      end else begin
        match_char(b.data);
      end
    end
    if (!b.last) return 1'b0;
    r.kind    = KIND_NONE;
    r.invalid = 1'b1;
    if (cand_s[KIND_OFF] && pos_s == cmd_word[KIND_OFF].len()) begin
      r.kind = KIND_OFF;
      r.invalid = 1'b0;
      off_s = 1'b1;
    end else if (cand_s[KIND_START] && pos_s == cmd_word[KIND_START].len()) begin
      r.kind = KIND_START;
      r.invalid = 1'b0;
      send_s = 1'b1;
    end else if (cand_s[KIND_STOP] && pos_s == cmd_word[KIND_STOP].len()) begin
      r.kind = KIND_STOP;
      r.invalid = 1'b0;
      send_s = 1'b0;
    end else if (cand_s[KIND_PERIOD] && pos_s >= PosDigits) begin
      r.kind = KIND_PERIOD;
      if (digits_ok_s && accum_s >= 12'd1 && accum_s <= PeriodMax) begin
        r.invalid = 1'b0;
        period_s = accum_s;
      end
    end else if (cand_s[KIND_SCALE] && pos_s >= cmd_word[KIND_SCALE].len()) begin
      r.kind = KIND_SCALE;
      if (pos_s == cmd_word[KIND_SCALE].len() + 1) begin
        if (arg_s == "F") begin
          r.invalid = 1'b0;
          cels_s = 1'b0;
        end else if (arg_s == "C") begin
          r.invalid = 1'b0;
          cels_s = 1'b1;
        end
      end
    end else if (cand_s[KIND_DISP] && pos_s >= cmd_word[KIND_DISP].len()) begin
      r.kind = KIND_DISP;
      if (pos_s == cmd_word[KIND_DISP].len() + 1) begin
        if (arg_s == "Y") begin
          r.invalid = 1'b0;
          disp_s = 1'b1;
        end else if (arg_s == "N") begin
          r.invalid = 1'b0;
          disp_s = 1'b0;
        end
      end
    end
    r.power_off  = off_s;
    r.sending    = send_s;
    r.celsius    = cels_s;
    r.display_on = disp_s;
    r.period     = period_s;
    restart_message();
    return 1'b1;
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // Compare a popped report with the oldest expected one
  task automatic check_report(input report_t got, input report_t want);
    if (got.kind !== want.kind) report_mismatch("command_kind", got.kind, want.kind);
    if (got.invalid !== want.invalid) report_mismatch("invalid", got.invalid, want.invalid);
    if (got.power_off !== want.power_off)
      report_mismatch("power_off", got.power_off, want.power_off);
    if (got.sending !== want.sending) report_mismatch("sending", got.sending, want.sending);
    if (got.celsius !== want.celsius) report_mismatch("celsius", got.celsius, want.celsius);
    if (got.display_on !== want.display_on)
      report_mismatch("display_on", got.display_on, want.display_on);
    if (got.period !== want.period)
      report_mismatch("period_seconds", got.period, want.period);
  endtask

  // Message building: collect bytes, then queue them with the last flag
  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_buf.push_back(s[i]);
  endfunction

  function automatic void commit_message();
    msg_byte_t b;
    if (msg_buf.size() == 0) msg_buf.push_back(8'h00);
    foreach (msg_buf[i]) begin
      b.data = msg_buf[i];
      b.last = (i == msg_buf.size() - 1);
      pending_q.push_back(b);
    end
    msg_buf.delete();
  endfunction

  function automatic void send_text(input string s);
    add_text(s);
    commit_message();
  endfunction

  function automatic void add_random_bytes(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(1, 0) == 1) msg_buf.push_back(8'($urandom_range(255, 0)));
      else msg_buf.push_back(8'($urandom_range(90, 32)));
    end
  endfunction

  // Build one random message: mostly commands with random arguments
  function automatic void random_message();
    int unsigned sel;
    int unsigned n;
    int unsigned k;
    int unsigned idx;
    sel = $urandom_range(99, 0);
    if (sel < 12) begin
      k = $urandom_range(4, 0);
      if (k == 0) add_text(cmd_word[KIND_OFF]);
      else if (k < 3) add_text(cmd_word[KIND_START]);
      else add_text(cmd_word[KIND_STOP]);
    end else if (sel < 37) begin
      add_text(cmd_word[KIND_PERIOD]);
      case ($urandom_range(7, 0))
        0:       n = $urandom_range(3, 0);
        1:       n = $urandom_range(3602, 3598);
        2:       n = $urandom_range(4100, 4090);
        3:       n = $urandom_range(999999, 4096);
        4:       n = $urandom_range(9, 1);
        default: n = $urandom_range(3600, 1);
      endcase
      if ($urandom_range(3, 0) == 0) repeat ($urandom_range(3, 1)) add_text("0");
      if (n != 0 || $urandom_range(1, 0) == 1) add_text($sformatf("%0d", n));
      // spoil the argument now and then
      if ($urandom_range(7, 0) == 0) begin
        idx = $urandom_range(msg_buf.size(), PosDigits);
        msg_buf.insert(idx, 8'($urandom_range(255, 1)));
      end
    end else if (sel < 52) begin
      add_text(cmd_word[KIND_SCALE]);
      case ($urandom_range(5, 0))
        0, 1:    add_text("C");
        2, 3:    add_text("F");
        4:       msg_buf.push_back(8'($urandom_range(255, 1)));
        default: ;
      endcase
      if ($urandom_range(7, 0) == 0) add_random_bytes($urandom_range(2, 1));
    end else if (sel < 67) begin
      add_text(cmd_word[KIND_DISP]);
      case ($urandom_range(5, 0))
        0, 1:    add_text("Y");
        2, 3:    add_text("N");
        4:       msg_buf.push_back(8'($urandom_range(255, 1)));
        default: ;
      endcase
      if ($urandom_range(7, 0) == 0) add_random_bytes($urandom_range(2, 1));
    end else if (sel < 82) begin
      // take a valid command and break it
      k = $urandom_range(NumCmds - 1, 0);
      add_text(cmd_word[k]);
      if (k == KIND_PERIOD) add_text("12");
      else if (k == KIND_SCALE) add_text("C");
      else if (k == KIND_DISP) add_text("N");
      idx = $urandom_range(msg_buf.size() - 1, 0);
      case ($urandom_range(4, 0))
        0: msg_buf[idx] = 8'($urandom_range(255, 0));
        1: msg_buf.delete(idx);
        2: add_random_bytes($urandom_range(3, 1));
        3: msg_buf[idx] = msg_buf[idx] ^ 8'h20;
        default: begin
          msg_buf.insert(idx, 8'h00);
          add_random_bytes($urandom_range(3, 0));
        end
      endcase
    end else begin
      add_random_bytes($urandom_range(20, 1));
    end
    // end the text early with a zero byte and trailing garbage
    if ($urandom_range(19, 0) == 0) begin
      msg_buf.push_back(8'h00);
      add_random_bytes($urandom_range(3, 0));
    end
    commit_message();
  endfunction

  // Known commands, argument limits and each odd case once
  function automatic void directed_messages();
    send_text("START");
    send_text("STOP");
    send_text("PERIOD=1");
    send_text("PERIOD=3600");
    send_text("PERIOD=3601");
    send_text("PERIOD=0");
    send_text("PERIOD=");
    send_text("PERIOD=0042");
    send_text("PERIOD=99999");
    send_text("PERIOD=12a");
    send_text("PERIOD=0000000000007");
    send_text("SCALE=C");
    send_text("SCALE=F");
    send_text("SCALE=x");
    send_text("SCALE=CF");
    send_text("DISP N");
    send_text("DISP Y");
    send_text("DISP Q");
    send_text("DISP");
    send_text("start");
    commit_message();
    add_text("STOP");
    msg_buf.push_back(8'h00);
    add_text("XYZ");
    commit_message();
    add_text(cmd_word[KIND_PERIOD]);
    msg_buf.push_back(8'hB1);
    commit_message();
    msg_buf.push_back(8'hFF);
    msg_buf.push_back(8'h80);
    commit_message();
    send_text("OFF");
    send_text("START");
    send_text("OF");
  endfunction

  // Clock
  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Sender: offer pending bytes, idle in bursts, pause once for a full drain
  always @(posedge clk_i) begin
    msg_byte_t got;
    msg_byte_t nxt;
    report_t   rep;
    int unsigned send_gap;
    if (!rst_ni) begin
      push     <= 1'b0;
      send_gap = 0;
    end else begin
      if (push && !full) begin
        got.data = message_byte_i;
        got.last = last_byte_i;
        if (predict_byte(got, rep)) expected_q.push_back(rep);
        sent_cnt++;
      end
      calm = (pending_q.size() < CalmItems);
      if (push && full) begin
        // hold the offered byte until it is taken
      end else if (send_gap != 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (sent_cnt == pause_at && expected_q.size() != 0) begin
        push <= 1'b0;
      end else if (pending_q.size() == 0) begin
        push <= 1'b0;
      end else if (!calm && $urandom_range(9, 0) == 0) begin
        send_gap = $urandom_range(6, 0);
        push <= 1'b0;
      end else begin
        nxt = pending_q.pop_front();
        push           <= 1'b1;
        message_byte_i <= nxt.data;
        last_byte_i    <= nxt.last;
      end
    end
  end

  // Receiver: check each transfer, idle in bursts, hold off once for long
  always @(posedge clk_i) begin
    report_t seen;
    report_t want;
    int unsigned recv_gap;
    int unsigned hold_left;
    bit held;
    if (!rst_ni) begin
      pop <= 1'b0;
      recv_gap  = 0;
      hold_left = 0;
      held      = 1'b0;
    end else begin
      if (pop && !empty) begin
        seen.kind       = kind_e'(command_kind_o);
        seen.invalid    = invalid_o;
        seen.power_off  = power_off_o;
        seen.sending    = sending_o;
        seen.celsius    = celsius_o;
        seen.display_on = display_on_o;
        seen.period     = period_seconds_o;
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("report with nothing expected", seen.kind, 0);
        end else begin
          want = expected_q.pop_front();
          check_report(seen, want);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!held && results_seen == HoldOffAfter) begin
        held      = 1'b1;
        hold_left = HoldOffCycles - 1;
        pop <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(9, 0) == 0) begin
        recv_gap = $urandom_range(6, 0);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("tb_sensor_command_parser_top: errors");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    off_s    = 1'b0;
    send_s   = 1'b1;
    cels_s   = 1'b0;
    disp_s   = 1'b1;
    period_s = PeriodInit;
    restart_message();
    directed_messages();
    pause_at = pending_q.size();
    while (pending_q.size() < pause_at + RandomItems) random_message();
    total_items = pending_q.size();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (sent_cnt != total_items || expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_sensor_command_parser_top: clean");
    end else begin
      $display("tb_sensor_command_parser_top: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/scp_pkg.sv
sv/scp_front.sv
sv/scp_queue.sv
sv/scp_back.sv
sv/sensor_command_parser_top.sv
bench/tb_sensor_command_parser_top.sv
